/* hdl/sfcf_pkg.sv */
// Shared types and constants for the stereo feedback comb filter.
`timescale 1ns / 1ps
package sfcf_pkg;
  localparam int unsigned SampleW = 24;
  localparam int unsigned FreqW   = 20;
  localparam int unsigned ResW    = 16;
  localparam int unsigned RateW   = 18;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSampleRate = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgNegFb      = 1'b1;
  localparam logic [RateW-1:0] SampleRateReset = 18'd48000;
  localparam logic signed [ResW-1:0] GainMax   = 16'sd16056;
  localparam logic signed [SampleW-1:0] OutLimit = 24'sd4194304;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
    logic [FreqW-1:0]          tune_frequency;
    logic signed [ResW-1:0]    resonance_amount;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
  } out_word_t;
endpackage

/* hdl/sfcf_if.sv */
// Valid/ready stream interface carrying one word.
`timescale 1ns / 1ps
interface sfcf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/sfcf_div.sv */
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sfcf_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DenW'(trial - {1'b0, den_q});
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DenW-1:0];
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

/* hdl/sfcf_lane.sv */
// One channel: delay line memory, interpolation, feedback and saturation.
`timescale 1ns / 1ps
module sfcf_lane #(
  parameter int unsigned AddrW = 12,
  parameter int unsigned FracW = 16
) (
  input  logic                          clk_i,
  input  logic                          clr_i,
  input  logic [AddrW-1:0]              clr_addr_i,
  input  logic                          rd_i,
  input  logic [AddrW-1:0]              rd_addr_i,
  input  logic [FracW-1:0]              frac_i,
  input  logic signed [sfcf_pkg::ResW-1:0] gain_i,
  input  logic signed [sfcf_pkg::SampleW-1:0] x_i,
  input  logic [2:0]                    phase_i,
  input  logic                          wr_i,
  input  logic [AddrW-1:0]              wr_addr_i,
  output logic signed [sfcf_pkg::SampleW-1:0] y_o
);
  import sfcf_pkg::*;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned InterpW = SampleW + FracW + 2;
  localparam int unsigned FbW = SampleW + ResW + 1;

  logic signed [SampleW-1:0] mem [Depth];
  logic signed [SampleW-1:0] rdata_q, a_q, b_q, rd_q, y_q;
  logic signed [InterpW-1:0] interp;
  logic signed [FbW-1:0] fb_prod;
  logic signed [FbW-1:0] fb_q;
  logic signed [FbW:0]   sum;
  logic [AddrW-1:0] rd_addr;
  logic signed [SampleW:0] diff;

  assign rd_addr = (phase_i == 3'd1) ? rd_addr_i - AddrW'(1) : rd_addr_i;

  always_ff @(posedge clk_i) begin
    if (clr_i) mem[clr_addr_i] <= '0;
    else if (wr_i) mem[wr_addr_i] <= y_q;
    if (rd_i) rdata_q <= mem[rd_addr];
  end

  // phase 1: A arrives, 2: B arrives, 3: interpolate, 4: feedback, 5: sum
  always_comb begin
    diff   = {b_q[SampleW-1], b_q} - {a_q[SampleW-1], a_q};
    interp = (InterpW'(a_q) <<< FracW) + InterpW'(diff) * $signed({1'b0, frac_i})
             + (InterpW'(1) <<< (FracW - 1));
    fb_prod = FbW'(gain_i) * FbW'(rd_q) + (FbW'(1) <<< 13);
    sum = (FbW+1)'(x_i) + (FbW+1)'(fb_q >>> 14);
  end

  always_ff @(posedge clk_i) begin
    if (phase_i == 3'd1) a_q <= rdata_q;
    if (phase_i == 3'd2) b_q <= rdata_q;
    if (phase_i == 3'd3) rd_q <= SampleW'(interp >>> FracW);
    if (phase_i == 3'd4) fb_q <= fb_prod;
    if (phase_i == 3'd5) begin
      if (sum > (FbW+1)'(OutLimit)) y_q <= OutLimit;
      else if (sum < -(FbW+1)'(OutLimit)) y_q <= -OutLimit;
      else y_q <= SampleW'(sum);
    end
  end

  assign y_o = y_q;
endmodule

/* hdl/stereo_feedback_comb_filter.sv */
// Stereo feedback comb filter top level.
// A word passes StPre and StChk, then the serial divide in StDiv unless the delay
// clamps to its maximum without it, then the lane phases in StRun, then StOut.
// A new word is accepted only in StIdle, after the last one has left StOut;
// a result held by the output stalls the block in its output state.
// Reset: clears control state, loads register defaults, then sweeps addresses
// 0 to DelayDepth-1 zeroing both delay lines before the first word is accepted.
`timescale 1ns / 1ps
module stereo_feedback_comb_filter #(
  parameter int unsigned DelayDepth = 4096,
  parameter int unsigned DelayFractionBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [sfcf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfcf_pkg::RateW-1:0] cfg_data_i,
  sfcf_if.sink   in_if,
  sfcf_if.source out_if
);
  import sfcf_pkg::*;
  localparam int unsigned AddrW = $clog2(DelayDepth);
  localparam int unsigned MaxD = DelayDepth - 3;
  localparam int unsigned NW = RateW + 4 + DelayFractionBits;
  localparam int unsigned DW = NW;
  localparam int unsigned ProdW = FreqW + AddrW + 1;

  typedef enum logic [6:0] {
    StClr = 7'b0000001, StIdle = 7'b0000010, StPre = 7'b0000100,
    StDiv = 7'b0001000, StRun = 7'b0010000, StOut = 7'b0100000,
    StChk = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [RateW-1:0] rate_q;
  logic neg_q;
  logic [AddrW-1:0] wp_q, clr_q;
  logic [FreqW-1:0] f_q;
  logic signed [SampleW-1:0] xl_q, xr_q;
  logic signed [ResW-1:0] gain_q, gain_c, res;
  logic [DW-1:0] delay_q;
  logic [2:0] ph_q;
  logic [23:0] rate36;
  logic [47:0] fmax_prod;
  logic [RateW+3:0] fmax;
  logic [ProdW-1:0] fprod;
  logic [RateW+3:0] n;
  logic div_start, div_done;
  logic [NW-1:0] quot;
  logic [DW-1:0] dsat;
  logic [AddrW-1:0] rd_addr;
  logic signed [SampleW-1:0] yl, yr;
  out_word_t out_q;
  logic out_v_q;
  logic out_go;

  // rate * 36 / 5 via reciprocal multiply, exact for products below 2^26
  assign rate36    = 24'({rate_q, 5'b0}) + 24'({rate_q, 2'b0});
  assign fmax_prod = 48'(rate36) * 48'd13421773;
  assign fmax      = (RateW+4)'(fmax_prod >> 26);
  assign n     = {rate_q, 4'b0};
  assign fprod = ProdW'(f_q) * ProdW'(MaxD);

  sfcf_div #(.NumW(NW), .DenW(FreqW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({n, DelayFractionBits'(0)}), .den_i(f_q),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    res = in_if.data.resonance_amount;
    if (res < 0) gain_c = '0;
    else if (res > GainMax) gain_c = GainMax;
    else gain_c = res;
    if (quot > DW'(MaxD) << DelayFractionBits) dsat = DW'(MaxD) << DelayFractionBits;
    else if (quot < DW'(2) << DelayFractionBits) dsat = DW'(2) << DelayFractionBits;
    else dsat = quot;
  end

  assign div_start = (state_q == StChk) && !(f_q == '0 || (ProdW+4)'(n) >= (ProdW+4)'(fprod));
  assign rd_addr   = wp_q - AddrW'(delay_q >> DelayFractionBits);
  assign in_if.ready = (state_q == StIdle);
  // output register free, or its word leaves this cycle
  assign out_go    = (state_q == StOut) && (!out_v_q || out_if.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClr:  if (clr_q == AddrW'(DelayDepth - 1)) state_d = StIdle;
      StIdle: if (in_if.valid && in_if.ready) state_d = StPre;
      StPre:  state_d = StChk;
      StChk:  state_d = div_start ? StDiv : StRun;
      StDiv:  if (div_done) state_d = StRun;
      StRun:  if (ph_q == 3'd6) state_d = StOut;
      StOut:  if (out_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      rate_q  <= SampleRateReset;
      neg_q   <= 1'b0;
      wp_q    <= '0;
      clr_q   <= '0;
      ph_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgSampleRate: rate_q <= cfg_data_i;
          CfgNegFb:      neg_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == StClr) clr_q <= clr_q + 1'b1;
      ph_q <= (state_q == StRun) ? ph_q + 1'b1 : '0;
      if (out_go) begin
        out_v_q <= 1'b1;
        wp_q <= wp_q + 1'b1;
      end else if (out_if.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      xl_q <= in_if.data.left_in;
      xr_q <= in_if.data.right_in;
      f_q  <= in_if.data.tune_frequency;
      gain_q <= neg_q ? -gain_c : gain_c;
    end
    if (state_q == StPre && (RateW+4)'(f_q) > fmax) f_q <= FreqW'(fmax);
    if (state_q == StChk) delay_q <= DW'(MaxD) << DelayFractionBits;
    if (state_q == StDiv && div_done) delay_q <= dsat;
    if (out_go) begin
      out_q.left_out  <= yl;
      out_q.right_out <= yr;
    end
  end

  sfcf_lane #(.AddrW(AddrW), .FracW(DelayFractionBits)) u_left (
    .clk_i, .clr_i(state_q == StClr), .clr_addr_i(clr_q),
    .rd_i(state_q == StRun), .rd_addr_i(rd_addr),
    .frac_i(delay_q[DelayFractionBits-1:0]), .gain_i(gain_q), .x_i(xl_q),
    .phase_i(ph_q), .wr_i(state_q == StOut), .wr_addr_i(wp_q), .y_o(yl)
  );
  sfcf_lane #(.AddrW(AddrW), .FracW(DelayFractionBits)) u_right (
    .clk_i, .clr_i(state_q == StClr), .clr_addr_i(clr_q),
    .rd_i(state_q == StRun), .rd_addr_i(rd_addr),
    .frac_i(delay_q[DelayFractionBits-1:0]), .gain_i(gain_q), .x_i(xr_q),
    .phase_i(ph_q), .wr_i(state_q == StOut), .wr_addr_i(wp_q), .y_o(yr)
  );

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;
endmodule
